// ===== hdl/searchable_sorting_fifo_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the searchable sorting FIFO
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SEARCHABLE_SORTING_FIFO_CORE_DEFINES_SVH
`define SEARCHABLE_SORTING_FIFO_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on a named clock, disabled while the named reset is low.
`define SSF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on the core clock and reset.
`define SSF_ASSERT(label, prop, msg) \
  `SSF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define SSF_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define SSF_ASSERT(label, prop, msg)
`endif

`endif

// ===== hdl/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// Searchable sorting FIFO package
// Sizes, command and status codes, and shared helpers for the FIFO core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssf_pkg;

  // Store geometry.
  localparam int unsigned DEPTH     = 64;
  localparam int unsigned ITEM_BITS = 8;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;

  // Command codes carried by the input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ        = 3'd0,
    CMD_DEQ        = 3'd1,
    CMD_CONTAINS   = 3'd2,
    CMD_ENQ_ABSENT = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_SORT       = 3'd5
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Write request to the entry memory.
  typedef struct packed {
    logic                 en;
    logic [PTR_W-1:0]     addr;
    logic [ITEM_BITS-1:0] data;
  } mem_wr_t;

  // Map a position in queue order onto a physical address of the ring.
  function automatic logic [PTR_W-1:0] phys_addr(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = sum - (PTR_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ssf_ram.sv =====
// ----------------------------------------------------------------------------
// Entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_ram (
  input  wire logic                          clk_i,
  input  wire ssf_pkg::mem_wr_t              wr_i,
  input  wire logic [ssf_pkg::PTR_W-1:0]     raddr_i,
  output logic      [ssf_pkg::ITEM_BITS-1:0] rdata_o
);
  import ssf_pkg::*;

  logic [ITEM_BITS-1:0] mem_q [DEPTH];
  logic [ITEM_BITS-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port; a read and a write of the same address returns old data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/searchable_sorting_fifo_core.sv =====
// ----------------------------------------------------------------------------
// Searchable sorting FIFO core
// Bounded FIFO with search, conditional enqueue, removal and in-place sort.
// ----------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o is low; its single
// result appears on the result ports for one cycle with done_o high, and the
// receiver cannot stall it. Entries live in a ring in one memory with a
// registered read, so the cost follows its single read port: enqueue returns
// its result in the cycle after acceptance, dequeue reads the head while idle
// and returns it from a dequeue state, contains, enqueue if absent and remove
// walk all N stored entries, and sort runs bubble passes over the entries
// until a pass makes no swap, at most N passes. No clearing pass follows
// reset.
`default_nettype none

module searchable_sorting_fifo_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ssf_pkg::CMD_W-1:0]     command_i,
  input  wire logic [ssf_pkg::ITEM_BITS-1:0] value_i,
  output logic                               done_o,
  output logic      [ssf_pkg::ITEM_BITS-1:0] out_value_o,
  output logic                               found_o,
  output logic      [ssf_pkg::CNT_W-1:0]     count_o,
  output logic      [ssf_pkg::STATUS_W-1:0]  status_o
);
  import ssf_pkg::*;

  `include "searchable_sorting_fifo_core_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN,
    ST_REMOVE,
    ST_SORT
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic [ITEM_BITS-1:0] val_q;
  logic [PTR_W-1:0]     head_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     rd_idx_q;
  logic [CNT_W-1:0]     wr_idx_q;
  logic                 rvalid_q;
  logic                 found_q;
  logic                 first_q;
  logic                 swap_q;
  logic [ITEM_BITS-1:0] max_q;

  logic                 done_q;
  logic [ITEM_BITS-1:0] res_value_q;
  logic                 res_found_q;
  logic [CNT_W-1:0]     res_count_q;
  status_e              res_status_q;

  mem_wr_t              mem_wr;
  logic [PTR_W-1:0]     mem_raddr;
  logic [ITEM_BITS-1:0] mem_rdata;

  logic                 accept;
  logic                 walking;
  logic                 rd_req;
  logic                 walk_end;
  logic                 hit;
  logic                 full;
  logic [PTR_W-1:0]     tail;
  logic [ITEM_BITS-1:0] sort_lo;
  logic [ITEM_BITS-1:0] sort_hi;

  ssf_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared decode of the scan pipeline.
  assign accept   = start_i && (state_q == ST_IDLE);
  assign walking  = (state_q == ST_SCAN) || (state_q == ST_REMOVE) || (state_q == ST_SORT);
  assign rd_req   = walking && (rd_idx_q < count_q);
  assign walk_end = walking && !rd_req && !rvalid_q;
  assign hit      = rvalid_q && (mem_rdata == val_q);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign tail     = phys_addr(head_q, count_q[PTR_W-1:0]);
  assign sort_lo  = (mem_rdata < max_q) ? mem_rdata : max_q;
  assign sort_hi  = (mem_rdata < max_q) ? max_q : mem_rdata;

  // Read address: the head while idle (dequeue), else the scan position.
  assign mem_raddr = (state_q == ST_IDLE) ? head_q
                                          : phys_addr(head_q, rd_idx_q[PTR_W-1:0]);

  // Write port selection; the cases never overlap in one cycle.
  always_comb begin
    mem_wr      = '0;
    mem_wr.data = value_i;
    mem_wr.addr = tail;
    if (accept && (command_i == CMD_ENQ) && !full) begin
      mem_wr.en = 1'b1;
    end else if ((state_q == ST_SCAN) && walk_end && (cmd_q == CMD_ENQ_ABSENT) &&
                 !found_q && !full) begin
      mem_wr.en   = 1'b1;
      mem_wr.data = val_q;
    end else if ((state_q == ST_REMOVE) && rvalid_q && !hit) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = phys_addr(head_q, wr_idx_q[PTR_W-1:0]);
      mem_wr.data = mem_rdata;
    end else if ((state_q == ST_SORT) && rvalid_q && !first_q) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = phys_addr(head_q, wr_idx_q[PTR_W-1:0]);
      mem_wr.data = sort_lo;
    end else if ((state_q == ST_SORT) && walk_end && (count_q != '0)) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = phys_addr(head_q, wr_idx_q[PTR_W-1:0]);
      mem_wr.data = max_q;
    end
  end

  // Control sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= CMD_ENQ;
      val_q        <= '0;
      head_q       <= '0;
      count_q      <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      rvalid_q     <= 1'b0;
      found_q      <= 1'b0;
      first_q      <= 1'b0;
      swap_q       <= 1'b0;
      max_q        <= '0;
      done_q       <= 1'b0;
      res_value_q  <= '0;
      res_found_q  <= 1'b0;
      res_count_q  <= '0;
      res_status_q <= STAT_OK;
    end else begin
      done_q <= 1'b0;
      // The read issued this cycle returns data in the next one.
      rvalid_q <= rd_req;
      if (rd_req) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q        <= cmd_e'(command_i);
            val_q        <= value_i;
            rd_idx_q     <= '0;
            wr_idx_q     <= '0;
            found_q      <= 1'b0;
            first_q      <= 1'b1;
            swap_q       <= 1'b0;
            res_value_q  <= '0;
            res_found_q  <= 1'b0;
            res_count_q  <= count_q;
            res_status_q <= STAT_OK;
            unique case (command_i)
              CMD_ENQ: begin
                done_q <= 1'b1;
                if (full) begin
                  res_status_q <= STAT_FULL;
                end else begin
                  count_q     <= count_q + CNT_W'(1);
                  res_count_q <= count_q + CNT_W'(1);
                end
              end
              CMD_DEQ: begin
                if (count_q == '0) begin
                  done_q       <= 1'b1;
                  res_status_q <= STAT_EMPTY;
                end else begin
                  state_q <= ST_DEQ;
                end
              end
              CMD_CONTAINS, CMD_ENQ_ABSENT: state_q <= ST_SCAN;
              CMD_REMOVE:                   state_q <= ST_REMOVE;
              CMD_SORT:                     state_q <= ST_SORT;
              default:                      done_q  <= 1'b1;
            endcase
          end
        end

        ST_DEQ: begin
          // Head data arrives in the cycle after the read issued while idle.
          res_value_q <= mem_rdata;
          head_q      <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
          count_q     <= count_q - CNT_W'(1);
          res_count_q <= count_q - CNT_W'(1);
          done_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end

        ST_SCAN: begin
          if (hit) begin
            found_q <= 1'b1;
          end
          if (walk_end) begin
            res_found_q <= found_q;
            if ((cmd_q == CMD_ENQ_ABSENT) && !found_q) begin
              if (full) begin
                res_status_q <= STAT_FULL;
              end else begin
                count_q     <= count_q + CNT_W'(1);
                res_count_q <= count_q + CNT_W'(1);
              end
            end
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end

        ST_REMOVE: begin
          // Survivors are compacted toward the head as they stream past.
          if (rvalid_q) begin
            if (hit) begin
              found_q <= 1'b1;
            end else begin
              wr_idx_q <= wr_idx_q + CNT_W'(1);
            end
          end
          if (walk_end) begin
            count_q     <= wr_idx_q;
            res_count_q <= wr_idx_q;
            res_found_q <= found_q;
            done_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        ST_SORT: begin
          // One bubble pass: carry the running maximum, write the smaller one back.
          if (rvalid_q) begin
            if (first_q) begin
              max_q   <= mem_rdata;
              first_q <= 1'b0;
            end else begin
              max_q    <= sort_hi;
              wr_idx_q <= wr_idx_q + CNT_W'(1);
              if (mem_rdata < max_q) begin
                swap_q <= 1'b1;
              end
            end
          end
          if (walk_end) begin
            if (swap_q) begin
              rd_idx_q <= '0;
              wr_idx_q <= '0;
              first_q  <= 1'b1;
              swap_q   <= 1'b0;
            end else begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign out_value_o = res_value_q;
  assign found_o     = res_found_q;
  assign count_o     = res_count_q;
  assign status_o    = res_status_q;

  // Checks on the occupancy bookkeeping and the reported status.
  `SSF_ASSERT(a_count_bound, (count_q <= CNT_W'(DEPTH)), "occupancy exceeds depth")
  `SSF_ASSERT(a_full_status, (done_o && (status_o == STAT_FULL)) |-> (count_o == CNT_W'(DEPTH)), "full status with free space")
  `SSF_ASSERT(a_empty_status, (done_o && (status_o == STAT_EMPTY)) |-> (count_o == '0), "empty status with entries")
  `SSF_ASSERT(a_count_moves_with_result, (count_q != $past(count_q)) |-> done_q, "occupancy changed without a result")

endmodule

`default_nettype wire

// ===== tb/ssf_result_checker.sv =====
// ----------------------------------------------------------------------------
// Result checker for the searchable sorting FIFO
// Watches the command and result channels of the core, keeps its own model
// of the queue contents, predicts every result word and compares it field by
// field with what the core returns.
// ----------------------------------------------------------------------------
module ssf_result_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          busy_i,
  input  wire logic [ssf_pkg::CMD_W-1:0]     command_i,
  input  wire logic [ssf_pkg::ITEM_BITS-1:0] value_i,
  input  wire logic                          done_i,
  input  wire logic [ssf_pkg::ITEM_BITS-1:0] out_value_i,
  input  wire logic                          found_i,
  input  wire logic [ssf_pkg::CNT_W-1:0]     count_i,
  input  wire logic [ssf_pkg::STATUS_W-1:0]  status_i,
  output int unsigned                        error_count_o,
  output int unsigned                        pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import ssf_pkg::*;

  // One predicted result word.
  typedef struct packed {
    logic [ITEM_BITS-1:0] out_value;
    logic                 found;
    logic [CNT_W-1:0]     count;
    status_e              status;
  } fifo_result_t;

  // Queue contents in order, head first.
  logic [ITEM_BITS-1:0] queue_model[$];
  // Results predicted but not yet returned by the core.
  fifo_result_t         awaited_results[$];
  int unsigned          mismatches;
  int unsigned          outstanding;

  assign error_count_o = mismatches;
  assign pending_o     = outstanding;

  // Apply one command word to the queue model and work out its result.
  task automatic apply_command(input logic [CMD_W-1:0] cmd,
                               input logic [ITEM_BITS-1:0] val,
                               output fifo_result_t res);
    logic [ITEM_BITS-1:0] kept[$];
    logic [ITEM_BITS-1:0] key;
    bit                   present;
    int                   i;
    int                   j;
    res     = '0;
    res.status = STAT_OK;
    present = 1'b0;
    foreach (queue_model[k]) begin
      if (queue_model[k] == val) present = 1'b1;
    end
    case (cmd)
      CMD_ENQ: begin
        if (queue_model.size() >= DEPTH) res.status = STAT_FULL;
        else queue_model.push_back(val);
      end
      CMD_DEQ: begin
        if (queue_model.size() == 0) res.status = STAT_EMPTY;
        else res.out_value = queue_model.pop_front();
      end
      CMD_CONTAINS: begin
        res.found = present;
      end
      CMD_ENQ_ABSENT: begin
        // A value already held is not added again; an absent one needs room.
        if (present) res.found = 1'b1;
        else if (queue_model.size() >= DEPTH) res.status = STAT_FULL;
        else queue_model.push_back(val);
      end
      CMD_REMOVE: begin
        foreach (queue_model[k]) begin
          if (queue_model[k] != val) kept.push_back(queue_model[k]);
        end
        res.found   = present;
        queue_model = kept;
      end
      CMD_SORT: begin
        // Insertion sort, ascending.
        for (i = 1; i < queue_model.size(); i++) begin
          key = queue_model[i];
          j   = i;
          while (j > 0 && queue_model[j-1] > key) begin
            queue_model[j] = queue_model[j-1];
            j--;
          end
          queue_model[j] = key;
        end
      end
      default: begin
        // Unused command codes leave the queue alone.
      end
    endcase
    res.count = CNT_W'(queue_model.size());
  endtask

  // Report one field that differs from its prediction.
  task automatic report_field(input string field, input int unsigned exp_val,
                              input int unsigned act_val);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val,
             act_val);
  endtask

  // Returned words are checked before a new command is predicted, so a word
  // that returns in the cycle a new command is taken meets the older entry.
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t exp_res;
    fifo_result_t new_res;
    if (!rst_ni) begin
      queue_model.delete();
      awaited_results.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (done_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, value %0d found %0d count %0d status %0d",
                   $time, out_value_i, found_i, count_i, status_i);
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_value_i !== exp_res.out_value)
            report_field("out_value", exp_res.out_value, out_value_i);
          if (found_i !== exp_res.found)
            report_field("found", exp_res.found, found_i);
          if (count_i !== exp_res.count)
            report_field("count", exp_res.count, count_i);
          if (status_i !== exp_res.status)
            report_field("status", exp_res.status, status_i);
        end
      end
      if (start_i && !busy_i) begin
        apply_command(command_i, value_i, new_res);
        awaited_results.push_back(new_res);
      end
      outstanding = awaited_results.size();
    end
  end

endmodule

// ===== tb/tb_searchable_sorting_fifo_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the searchable sorting FIFO core
// Sends a directed sequence covering the empty corners, every
// command and the unused codes, then phases of random commands that lean
// toward filling, draining or mixing the queue. A checker beside the core
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_searchable_sorting_fifo_core;

  timeunit 1ns;
  timeprecision 1ps;

  import ssf_pkg::*;

  // Command codes that the core does not define.
  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

  // Phase flavors of the random part.
  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_e;

  localparam int unsigned RANDOM_WORDS = 1150;
  // Watchdog limit, well above the longest sort of a full store.
  localparam int unsigned IDLE_LIMIT   = 20000;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 start_i   = 1'b0;
  logic [CMD_W-1:0]     command_i = '0;
  logic [ITEM_BITS-1:0] value_i   = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [ITEM_BITS-1:0] out_value_o;
  logic                 found_o;
  logic [CNT_W-1:0]     count_o;
  logic [STATUS_W-1:0]  status_o;

  int unsigned error_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  logic [ITEM_BITS-1:0] value_pool[8];

  always #10 clk_i = ~clk_i;

  searchable_sorting_fifo_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .out_value_o(out_value_o),
    .found_o    (found_o),
    .count_o    (count_o),
    .status_o   (status_o)
  );

  ssf_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .done_i       (done_o),
    .out_value_i  (out_value_o),
    .found_i      (found_o),
    .count_i      (count_o),
    .status_i     (status_o),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_searchable_sorting_fifo_core: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Send one command word. Bursts of random length are separated by random
  // gaps during which start is low and the payload carries noise.
  task automatic send_word(input logic [CMD_W-1:0] cmd,
                           input logic [ITEM_BITS-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        start_i   <= 1'b0;
        command_i <= CMD_W'($urandom);
        value_i   <= ITEM_BITS'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  // Values mostly come from a small pool so searches and removals hit.
  function automatic logic [ITEM_BITS-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
    return ITEM_BITS'($urandom_range(0, 255));
  endfunction

  // Pick a command with weights that depend on the phase flavor.
  function automatic logic [CMD_W-1:0] pick_command(input phase_e flavor);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (flavor)
      PHASE_FILL: begin
        if (roll < 55) return CMD_ENQ;
        if (roll < 70) return CMD_ENQ_ABSENT;
        if (roll < 80) return CMD_CONTAINS;
        if (roll < 88) return CMD_DEQ;
        if (roll < 93) return CMD_REMOVE;
        if (roll < 97) return CMD_SORT;
      end
      PHASE_DRAIN: begin
        if (roll < 50) return CMD_DEQ;
        if (roll < 70) return CMD_REMOVE;
        if (roll < 80) return CMD_CONTAINS;
        if (roll < 90) return CMD_ENQ;
        if (roll < 95) return CMD_SORT;
        if (roll < 98) return CMD_ENQ_ABSENT;
      end
      default: begin
        if (roll < 25) return CMD_ENQ;
        if (roll < 45) return CMD_DEQ;
        if (roll < 60) return CMD_CONTAINS;
        if (roll < 75) return CMD_ENQ_ABSENT;
        if (roll < 88) return CMD_REMOVE;
        if (roll < 95) return CMD_SORT;
      end
    endcase
    return ($urandom_range(0, 1) == 0) ? CMD_RSVD_A : CMD_RSVD_B;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    phase_e      flavor;
    bit          first_phase;

    foreach (value_pool[k]) value_pool[k] = ITEM_BITS'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty corners, every command, duplicates, unused codes.
    send_word(CMD_DEQ,        8'h00);
    send_word(CMD_CONTAINS,   8'h5A);
    send_word(CMD_SORT,       8'h00);
    send_word(CMD_REMOVE,     8'h5A);
    send_word(CMD_ENQ,        8'hFF);
    send_word(CMD_ENQ,        8'h00);
    send_word(CMD_ENQ,        8'hA5);
    send_word(CMD_ENQ,        8'h5A);
    send_word(CMD_ENQ,        8'hA5);
    send_word(CMD_CONTAINS,   8'hA5);
    send_word(CMD_CONTAINS,   8'h01);
    send_word(CMD_ENQ_ABSENT, 8'h00);
    send_word(CMD_ENQ_ABSENT, 8'h7E);
    send_word(CMD_REMOVE,     8'hA5);
    send_word(CMD_REMOVE,     8'h33);
    send_word(CMD_RSVD_A,     8'hFF);
    send_word(CMD_RSVD_B,     8'h00);
    send_word(CMD_SORT,       8'hFF);
    repeat (5) send_word(CMD_DEQ, 8'hFF);

    // Random part: the first phase is long and fill-heavy so the store
    // reaches full and refuses both kinds of enqueue.
    sent        = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_WORDS) begin
      if (first_phase) begin
        flavor    = PHASE_FILL;
        phase_len = 140;
      end else begin
        flavor    = phase_e'($urandom_range(0, 2));
        phase_len = $urandom_range(40, 120);
      end
      first_phase = 1'b0;
      repeat (phase_len) begin
        send_word(pick_command(flavor), pick_value());
        sent++;
      end
    end
    start_i <= 1'b0;

    // Drain the outstanding results, then allow for stray words.
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("tb_searchable_sorting_fifo_core: done, clean");
    end else begin
      $display("tb_searchable_sorting_fifo_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ssf_pkg.sv
hdl/ssf_ram.sv
hdl/searchable_sorting_fifo_core.sv
tb/ssf_result_checker.sv
tb/tb_searchable_sorting_fifo_core.sv
